>>> rtl/axis_angle_rotation_matrix_unit_defines.svh
// assertion macros shared by the rotation matrix unit
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_DEFINES_SVH

// property checked on every clock edge out of reset
`define AARM_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define AARM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/aarm_pkg.sv
// shared types, constants and helper functions of the rotation matrix unit
package aarm_pkg;

  localparam int AX_W         = 16;
  localparam int Q_W          = 16;
  localparam int LEN_W        = 32;
  localparam int SQRT_PAD     = 28;
  localparam int ROOT_W       = 30;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int SQRT_REM_W   = 32;
  localparam int DIV_STEPS    = 15;
  localparam int DIV_REM_W    = AX_W + SQRT_PAD;
  localparam int CZ_W         = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITER  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int NORM_LAT     = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int CORD_LAT     = CORDIC_ITER + 1;
  localparam int CS_DELAY     = NORM_LAT - CORD_LAT;
  localparam int MAT_LAT      = 3;

  localparam logic signed [CZ_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Q_W-1:0]  ONE_Q14     = 16'sd16384;

  typedef logic signed [AX_W-1:0] axis_t;
  typedef logic signed [Q_W-1:0]  q14_t;

  // control bits that travel with each request
  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  // arctangent table in q2.30
  function automatic logic signed [CZ_W-1:0] atan_q30(input int i);
    case (i)
      0:  return 34'sd843314857;
      1:  return 34'sd497837830;
      2:  return 34'sd263043837;
      3:  return 34'sd133525159;
      4:  return 34'sd67021687;
      5:  return 34'sd33543516;
      6:  return 34'sd16775851;
      7:  return 34'sd8388437;
      8:  return 34'sd4194283;
      9:  return 34'sd2097149;
      10: return 34'sd1048576;
      11: return 34'sd524288;
      12: return 34'sd262144;
      13: return 34'sd131072;
      14: return 34'sd65536;
      15: return 34'sd32768;
      16: return 34'sd16384;
      17: return 34'sd8192;
      18: return 34'sd4096;
      19: return 34'sd2048;
      20: return 34'sd1024;
      21: return 34'sd512;
      22: return 34'sd256;
      23: return 34'sd128;
      default: return '0;
    endcase
  endfunction

  // saturate to the q1.14 unit range
  function automatic q14_t clamp_q14(input logic signed [47:0] v);
    if (v > 48'sd16384) begin
      return ONE_Q14;
    end else if (v < -48'sd16384) begin
      return -ONE_Q14;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

endpackage

>>> rtl/aarm_sqrt.sv
// squared axis length and pipelined integer square root, one result bit a stage
module aarm_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  aarm_pkg::axis_t             in_axis [3],
  output aarm_pkg::ctl_t              out_ctl,
  output logic [aarm_pkg::ROOT_W-1:0] out_root,
  output aarm_pkg::axis_t             out_axis [3]
);

  localparam int NS = aarm_pkg::SQRT_STEPS;

  logic                          s0_vld_r;
  logic [aarm_pkg::LEN_W-1:0]    s0_sq_r [3];
  aarm_pkg::axis_t               s0_ax_r [3];
  aarm_pkg::ctl_t                s1_ctl_r;
  logic [aarm_pkg::LEN_W-1:0]    s1_len_r;
  aarm_pkg::axis_t               s1_ax_r [3];
  logic signed [aarm_pkg::LEN_W-1:0] sq_nxt [3];
  logic [aarm_pkg::LEN_W-1:0]    len_nxt;

  logic [aarm_pkg::LEN_W-1:0]      st_len_r  [NS];
  logic [aarm_pkg::SQRT_REM_W-1:0] st_rem_r  [NS];
  logic [aarm_pkg::ROOT_W-1:0]     st_root_r [NS];
  aarm_pkg::ctl_t                  st_ctl_r  [NS];
  aarm_pkg::axis_t                 st_ax_r   [NS][3];

  // component squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = in_axis[i] * in_axis[i];
    end
  end

  assign len_nxt = s0_sq_r[0] + s0_sq_r[1] + s0_sq_r[2];

  // square and sum stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_ctl_r <= '0;
    end else begin
      s0_vld_r      <= in_vld;
      s1_ctl_r.vld  <= s0_vld_r;
      s1_ctl_r.zero <= (len_nxt == '0);
    end
    for (int i = 0; i < 3; i++) begin
      s0_sq_r[i] <= aarm_pkg::LEN_W'(unsigned'(sq_nxt[i]));
      s0_ax_r[i] <= in_axis[i];
      s1_ax_r[i] <= s0_ax_r[i];
    end
    s1_len_r <= len_nxt;
  end

  // digit-by-digit root of len * 2^28
  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int P = NS - 1 - j;
    logic [aarm_pkg::LEN_W-1:0]      len_in;
    logic [aarm_pkg::SQRT_REM_W-1:0] rem_in;
    logic [aarm_pkg::ROOT_W-1:0]     root_in;
    aarm_pkg::ctl_t                  ctl_in;
    aarm_pkg::axis_t                 ax_in [3];
    logic [1:0]                      pair;
    logic [aarm_pkg::SQRT_REM_W+1:0] rem_sh;
    logic [aarm_pkg::SQRT_REM_W+1:0] trial;
    logic [aarm_pkg::SQRT_REM_W+1:0] diff;
    logic                            ge;

    if (j == 0) begin : g_first
      assign len_in  = s1_len_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctl_in  = s1_ctl_r;
      assign ax_in   = s1_ax_r;
    end else begin : g_next
      assign len_in  = st_len_r[j-1];
      assign rem_in  = st_rem_r[j-1];
      assign root_in = st_root_r[j-1];
      assign ctl_in  = st_ctl_r[j-1];
      assign ax_in   = st_ax_r[j-1];
    end

    // radicand bits below the pad are zero
    if (P >= aarm_pkg::SQRT_PAD / 2) begin : g_pair
      assign pair = len_in[2*P-aarm_pkg::SQRT_PAD+1 -: 2];
    end else begin : g_pad
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_in, pair};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_ctl_r[j] <= '0;
      end else begin
        st_ctl_r[j] <= ctl_in;
      end
      st_len_r[j]  <= len_in;
      st_rem_r[j]  <= ge ? diff[aarm_pkg::SQRT_REM_W-1:0] : rem_sh[aarm_pkg::SQRT_REM_W-1:0];
      st_root_r[j] <= {root_in[aarm_pkg::ROOT_W-2:0], ge};
      st_ax_r[j]   <= ax_in;
    end
  end

  assign out_ctl  = st_ctl_r[NS-1];
  assign out_root = st_root_r[NS-1];
  assign out_axis = st_ax_r[NS-1];

endmodule

>>> rtl/aarm_div.sv
// restoring divider lanes that scale each axis component to unit length
module aarm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aarm_pkg::ctl_t              in_ctl,
  input  logic [aarm_pkg::ROOT_W-1:0] in_root,
  input  aarm_pkg::axis_t             in_axis [3],
  output aarm_pkg::ctl_t              out_ctl,
  output aarm_pkg::q14_t              out_n [3]
);

  localparam int ND = aarm_pkg::DIV_STEPS;
  localparam int RW = aarm_pkg::DIV_REM_W;

  aarm_pkg::ctl_t              p_ctl_r;
  logic [aarm_pkg::ROOT_W-1:0] p_root_r;
  logic [RW-1:0]               p_num_r [3];
  logic                        p_neg_r [3];

  logic [RW-1:0]               st_rem_r  [ND][3];
  logic [ND-1:0]               st_q_r    [ND][3];
  logic                        st_neg_r  [ND][3];
  logic [aarm_pkg::ROOT_W-1:0] st_root_r [ND];
  aarm_pkg::ctl_t              st_ctl_r  [ND];

  aarm_pkg::ctl_t              f_ctl_r;
  aarm_pkg::q14_t              f_n_r [3];

  logic [aarm_pkg::AX_W-1:0]   mag [3];
  aarm_pkg::q14_t              qs  [3];

  // magnitude with rounding offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_axis[i][aarm_pkg::AX_W-1] ? aarm_pkg::AX_W'(-in_axis[i])
                                            : aarm_pkg::AX_W'(in_axis[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
    end else begin
      p_ctl_r <= in_ctl;
    end
    p_root_r <= in_root;
    for (int i = 0; i < 3; i++) begin
      p_num_r[i] <= {mag[i], aarm_pkg::SQRT_PAD'(0)} + RW'(in_root >> 1);
      p_neg_r[i] <= in_axis[i][aarm_pkg::AX_W-1];
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < ND; j++) begin : g_step
    localparam int K = ND - 1 - j;
    logic [RW-1:0]               rem_in  [3];
    logic [ND-1:0]               q_in    [3];
    logic                        neg_in  [3];
    logic [aarm_pkg::ROOT_W-1:0] root_in;
    aarm_pkg::ctl_t              ctl_in;
    logic [RW-1:0]               dvs;
    logic                        ge      [3];
    logic [RW-1:0]               rem_nxt [3];

    if (j == 0) begin : g_first
      assign rem_in  = p_num_r;
      assign neg_in  = p_neg_r;
      assign root_in = p_root_r;
      assign ctl_in  = p_ctl_r;
      for (genvar i = 0; i < 3; i++) begin : g_q
        assign q_in[i] = '0;
      end
    end else begin : g_next
      assign rem_in  = st_rem_r[j-1];
      assign q_in    = st_q_r[j-1];
      assign neg_in  = st_neg_r[j-1];
      assign root_in = st_root_r[j-1];
      assign ctl_in  = st_ctl_r[j-1];
    end

    assign dvs = RW'(root_in) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]      = (rem_in[i] >= dvs);
        rem_nxt[i] = ge[i] ? rem_in[i] - dvs : rem_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_ctl_r[j] <= '0;
      end else begin
        st_ctl_r[j] <= ctl_in;
      end
      st_root_r[j] <= root_in;
      for (int i = 0; i < 3; i++) begin
        st_rem_r[j][i] <= rem_nxt[i];
        st_q_r[j][i]   <= {q_in[i][ND-2:0], ge[i]};
        st_neg_r[j][i] <= neg_in[i];
      end
    end
  end

  // restore sign, saturate, zero axis stays zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = st_neg_r[ND-1][i] ? -aarm_pkg::q14_t'({1'b0, st_q_r[ND-1][i]})
                                : aarm_pkg::q14_t'({1'b0, st_q_r[ND-1][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_ctl_r <= '0;
    end else begin
      f_ctl_r <= st_ctl_r[ND-1];
    end
    for (int i = 0; i < 3; i++) begin
      f_n_r[i] <= st_ctl_r[ND-1].zero ? '0 : aarm_pkg::clamp_q14(48'(qs[i]));
    end
  end

  assign out_ctl = f_ctl_r;
  assign out_n   = f_n_r;

endmodule

>>> rtl/aarm_cordic.sv
// pipelined rotation-mode cordic for cosine and sine, delayed to meet the unit axis
module aarm_cordic (
  input  logic            clk,
  input  aarm_pkg::axis_t in_angle,
  output aarm_pkg::q14_t  out_cos,
  output aarm_pkg::q14_t  out_sin
);

  localparam int NI = aarm_pkg::CORDIC_ITER;
  localparam int CW = aarm_pkg::CZ_W;
  localparam int ND = aarm_pkg::CS_DELAY;

  logic signed [CW-1:0] p_z_r;
  logic                 p_neg_r;
  logic signed [CW-1:0] z_in;
  logic signed [CW-1:0] z_adj;
  logic                 neg_nxt;

  logic signed [CW-1:0] st_x_r   [NI];
  logic signed [CW-1:0] st_y_r   [NI];
  logic signed [CW-1:0] st_z_r   [NI];
  logic                 st_neg_r [NI];

  logic signed [CW-1:0] xs, ys, xr, yr;
  aarm_pkg::q14_t       dc_r [ND];
  aarm_pkg::q14_t       ds_r [ND];

  // angle into q2.30 and folded into the convergence range
  assign z_in = $signed({in_angle[aarm_pkg::AX_W-1], in_angle, 17'b0});

  always_comb begin
    z_adj   = z_in;
    neg_nxt = 1'b0;
    if (z_in > aarm_pkg::HALF_PI_Q30) begin
      z_adj   = z_in - aarm_pkg::PI_Q30;
      neg_nxt = 1'b1;
    end else if (z_in < -aarm_pkg::HALF_PI_Q30) begin
      z_adj   = z_in + aarm_pkg::PI_Q30;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    p_z_r   <= z_adj;
    p_neg_r <= neg_nxt;
  end

  // micro-rotation stages
  for (genvar j = 0; j < NI; j++) begin : g_step
    localparam logic signed [CW-1:0] AT = aarm_pkg::atan_q30(j);
    logic signed [CW-1:0] x_in, y_in, zz_in;
    logic                 neg_in;
    logic signed [CW-1:0] dx, dy;

    if (j == 0) begin : g_first
      assign x_in   = aarm_pkg::CORDIC_GAIN;
      assign y_in   = '0;
      assign zz_in  = p_z_r;
      assign neg_in = p_neg_r;
    end else begin : g_next
      assign x_in   = st_x_r[j-1];
      assign y_in   = st_y_r[j-1];
      assign zz_in  = st_z_r[j-1];
      assign neg_in = st_neg_r[j-1];
    end

    assign dx = y_in >>> j;
    assign dy = x_in >>> j;

    always_ff @(posedge clk) begin
      if (!zz_in[CW-1]) begin
        st_x_r[j] <= x_in - dx;
        st_y_r[j] <= y_in + dy;
        st_z_r[j] <= zz_in - AT;
      end else begin
        st_x_r[j] <= x_in + dx;
        st_y_r[j] <= y_in - dy;
        st_z_r[j] <= zz_in + AT;
      end
      st_neg_r[j] <= neg_in;
    end
  end

  // undo the fold, round to q1.14 and saturate
  assign xs = st_neg_r[NI-1] ? -st_x_r[NI-1] : st_x_r[NI-1];
  assign ys = st_neg_r[NI-1] ? -st_y_r[NI-1] : st_y_r[NI-1];
  assign xr = (xs + CW'(32768)) >>> 16;
  assign yr = (ys + CW'(32768)) >>> 16;

  // delay line to line up with the normalised axis
  always_ff @(posedge clk) begin
    dc_r[0] <= aarm_pkg::clamp_q14(48'(xr));
    ds_r[0] <= aarm_pkg::clamp_q14(48'(yr));
    for (int k = 1; k < ND; k++) begin
      dc_r[k] <= dc_r[k-1];
      ds_r[k] <= ds_r[k-1];
    end
  end

  assign out_cos = dc_r[ND-1];
  assign out_sin = ds_r[ND-1];

endmodule

>>> rtl/aarm_matrix.sv
// rodrigues matrix assembly: products, scaling, then rounded sums
module aarm_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  aarm_pkg::ctl_t in_ctl,
  input  aarm_pkg::q14_t in_n [3],
  input  aarm_pkg::q14_t in_cos,
  input  aarm_pkg::q14_t in_sin,
  output aarm_pkg::ctl_t out_ctl,
  output aarm_pkg::q14_t out_m [9]
);

  aarm_pkg::ctl_t     m1_ctl_r, m2_ctl_r, m3_ctl_r;
  logic signed [31:0] m1_pp_r [6];
  logic signed [31:0] m1_ns_r [3];
  logic signed [17:0] m1_t_r;
  aarm_pkg::q14_t     m1_c_r;
  logic signed [45:0] m2_a_r [6];
  logic signed [45:0] m2_b_r [3];
  logic signed [45:0] m2_cd_r;
  aarm_pkg::q14_t     m3_m_r [9];

  logic signed [31:0] pp_nxt [6];
  logic signed [31:0] ns_nxt [3];
  logic signed [49:0] a_nxt  [6];
  logic signed [46:0] ea [6];
  logic signed [46:0] eb [3];
  logic signed [46:0] ec;
  logic signed [46:0] sm [9];

  // round half up at scale 2^28 and saturate
  function automatic aarm_pkg::q14_t entry(input logic signed [46:0] sum);
    logic signed [46:0] rs;
    rs = (sum + 47'sd134217728) >>> 28;
    return aarm_pkg::clamp_q14(48'(rs));
  endfunction

  // axis products: n0n0 n1n1 n2n2 n0n1 n0n2 n1n2, then n times sine
  always_comb begin
    pp_nxt[0] = in_n[0] * in_n[0];
    pp_nxt[1] = in_n[1] * in_n[1];
    pp_nxt[2] = in_n[2] * in_n[2];
    pp_nxt[3] = in_n[0] * in_n[1];
    pp_nxt[4] = in_n[0] * in_n[2];
    pp_nxt[5] = in_n[1] * in_n[2];
    for (int i = 0; i < 3; i++) begin
      ns_nxt[i] = in_n[i] * in_sin;
    end
    for (int i = 0; i < 6; i++) begin
      a_nxt[i] = m1_pp_r[i] * m1_t_r;
    end
  end

  // sums with the rodrigues signs
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ea[i] = 47'(m2_a_r[i]);
    end
    for (int i = 0; i < 3; i++) begin
      eb[i] = 47'(m2_b_r[i]);
    end
    ec    = 47'(m2_cd_r);
    sm[0] = ec + ea[0];
    sm[1] = ea[3] - eb[2];
    sm[2] = ea[4] + eb[1];
    sm[3] = ea[3] + eb[2];
    sm[4] = ec + ea[1];
    sm[5] = ea[5] - eb[0];
    sm[6] = ea[4] - eb[1];
    sm[7] = ea[5] + eb[0];
    sm[8] = ec + ea[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r <= '0;
      m2_ctl_r <= '0;
      m3_ctl_r <= '0;
    end else begin
      m1_ctl_r <= in_ctl;
      m2_ctl_r <= m1_ctl_r;
      m3_ctl_r <= m2_ctl_r;
    end
    m1_pp_r <= pp_nxt;
    m1_ns_r <= ns_nxt;
    m1_t_r  <= 18'sd16384 - 18'(in_cos);
    m1_c_r  <= in_cos;
    for (int i = 0; i < 6; i++) begin
      m2_a_r[i] <= a_nxt[i][45:0];
    end
    for (int i = 0; i < 3; i++) begin
      m2_b_r[i] <= 46'(m1_ns_r[i]) <<< 14;
    end
    m2_cd_r <= 46'(m1_c_r) <<< 28;
    for (int i = 0; i < 9; i++) begin
      m3_m_r[i] <= entry(sm[i]);
    end
  end

  assign out_ctl = m3_ctl_r;
  assign out_m   = m3_m_r;

endmodule

>>> rtl/axis_angle_rotation_matrix_unit.sv
// axis-angle to rotation matrix top level
// throughput: one request per cycle, busy stays low; depth is set by the
// 30-stage square root and 15-stage divider chain, the cordic runs beside it
// reset: synchronous active-low rst_n clears every valid bit; no strobe follows
// until new requests arrive, and results cannot be held off by the receiver
`include "axis_angle_rotation_matrix_unit_defines.svh"

module axis_angle_rotation_matrix_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    in_axis_x,
  input  logic signed [15:0]    in_axis_y,
  input  logic signed [15:0]    in_axis_z,
  input  logic signed [15:0]    in_turn_angle,
  output logic                  out_valid,
  output logic signed [15:0]    out_m00,
  output logic signed [15:0]    out_m01,
  output logic signed [15:0]    out_m02,
  output logic signed [15:0]    out_m10,
  output logic signed [15:0]    out_m11,
  output logic signed [15:0]    out_m12,
  output logic signed [15:0]    out_m20,
  output logic signed [15:0]    out_m21,
  output logic signed [15:0]    out_m22,
  output logic                  out_zero_axis
);

  logic                        in_acc;
  aarm_pkg::axis_t             axis_in [3];
  aarm_pkg::ctl_t              sq_ctl;
  logic [aarm_pkg::ROOT_W-1:0] sq_root;
  aarm_pkg::axis_t             sq_axis [3];
  aarm_pkg::ctl_t              nrm_ctl;
  aarm_pkg::q14_t              nrm_n [3];
  aarm_pkg::q14_t              cs_cos, cs_sin;
  aarm_pkg::ctl_t              mat_ctl;
  aarm_pkg::q14_t              mat_m [9];

  // fully pipelined, never stalls
  assign busy    = 1'b0;
  assign in_acc  = start && !busy;
  assign axis_in = '{in_axis_x, in_axis_y, in_axis_z};

  aarm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_acc),
    .in_axis  (axis_in),
    .out_ctl  (sq_ctl),
    .out_root (sq_root),
    .out_axis (sq_axis)
  );

  aarm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (sq_ctl),
    .in_root (sq_root),
    .in_axis (sq_axis),
    .out_ctl (nrm_ctl),
    .out_n   (nrm_n)
  );

  aarm_cordic u_cordic (
    .clk      (clk),
    .in_angle (in_turn_angle),
    .out_cos  (cs_cos),
    .out_sin  (cs_sin)
  );

  aarm_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (nrm_ctl),
    .in_n    (nrm_n),
    .in_cos  (cs_cos),
    .in_sin  (cs_sin),
    .out_ctl (mat_ctl),
    .out_m   (mat_m)
  );

  // result ports
  assign out_valid     = mat_ctl.vld;
  assign out_zero_axis = mat_ctl.zero;
  assign out_m00       = mat_m[0];
  assign out_m01       = mat_m[1];
  assign out_m02       = mat_m[2];
  assign out_m10       = mat_m[3];
  assign out_m11       = mat_m[4];
  assign out_m12       = mat_m[5];
  assign out_m20       = mat_m[6];
  assign out_m21       = mat_m[7];
  assign out_m22       = mat_m[8];

  // checks
  `AARM_ASSERT_IMP(a_diag_range, out_valid, (out_m00 <= 16'sd16384) && (out_m00 >= -16'sd16384) && (out_m11 <= 16'sd16384) && (out_m11 >= -16'sd16384), "diagonal entry out of unit range")
  `AARM_ASSERT_IMP(a_zero_axis_form, out_valid && out_zero_axis, (out_m01 == 16'sd0) && (out_m12 == 16'sd0) && (out_m20 == 16'sd0) && (out_m00 == out_m11) && (out_m11 == out_m22), "zero axis result is not cosine times identity")
  `AARM_ASSERT_IMP(a_valid_chain, out_valid, $past(nrm_ctl.vld, aarm_pkg::MAT_LAT), "result strobe without a normalised axis in flight")

endmodule

>>> sim/tb_axis_angle_rotation_matrix_unit.sv
// testbench for the axis-angle to rotation matrix unit: random and directed requests
`timescale 1ns / 100ps

module tb_axis_angle_rotation_matrix_unit;

  localparam int  RANDOM_ITEMS = 1300;
  localparam int  DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 400000;

  localparam longint ONE_UNIT  = 16384;
  localparam longint GAIN_Q30  = 652032874;
  localparam longint PI_Z      = 64'sd3373259426;
  localparam longint HALF_PI_Z = 1686629713;

  typedef struct {
    aarm_pkg::axis_t ax;
    aarm_pkg::axis_t ay;
    aarm_pkg::axis_t az;
    aarm_pkg::axis_t angle;
  } rot_request_t;

  typedef struct {
    aarm_pkg::q14_t m[9];
    bit   zero_axis;
  } rot_matrix_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  aarm_pkg::axis_t in_axis_x, in_axis_y, in_axis_z, in_turn_angle;
  logic  out_valid;
  aarm_pkg::q14_t  out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  aarm_pkg::q14_t  out_m20, out_m21, out_m22;
  logic  out_zero_axis;

  rot_request_t pending_requests[$];
  rot_matrix_t  expected_matrices[$];
  int           error_count;
  int           accepted_count;
  longint       cycle_count;

  axis_angle_rotation_matrix_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_axis_x     (in_axis_x),
    .in_axis_y     (in_axis_y),
    .in_axis_z     (in_axis_z),
    .in_turn_angle (in_turn_angle),
    .out_valid     (out_valid),
    .out_m00       (out_m00),
    .out_m01       (out_m01),
    .out_m02       (out_m02),
    .out_m10       (out_m10),
    .out_m11       (out_m11),
    .out_m12       (out_m12),
    .out_m20       (out_m20),
    .out_m21       (out_m21),
    .out_m22       (out_m22),
    .out_zero_axis (out_zero_axis)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // saturate to the unit range
  function automatic longint sat_unit(input longint v);
    if (v > ONE_UNIT) return ONE_UNIT;
    if (v < -ONE_UNIT) return -ONE_UNIT;
    return v;
  endfunction

  // round a 2^28 scaled sum half up into q1.14
  function automatic aarm_pkg::q14_t round_entry(input longint sum);
    longint r;
    r = sat_unit((sum + (longint'(1) <<< 27)) >>> 28);
    return aarm_pkg::q14_t'(r);
  endfunction

  // rodrigues matrix from the raw axis and angle
  function automatic rot_matrix_t predict_rotation(input rot_request_t rq);
    rot_matrix_t res;
    longint v[3];
    longint n[3];
    longint zq, cx, cy, dx, dy, c, s, t, q;
    longint unsigned len2, rem, root, bt, mag;
    bit flip;
    v[0] = rq.ax;
    v[1] = rq.ay;
    v[2] = rq.az;
    n = '{0, 0, 0};
    flip = 1'b0;
    len2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    res.zero_axis = (len2 == 0);
    // normalise the axis: root of the length in q.14, then rounded division
    if (!res.zero_axis) begin
      rem = len2 << 28;
      root = 0;
      bt = 64'd1 << 62;
      while (bt > rem) bt = bt >> 2;
      while (bt != 0) begin
        if (rem >= root + bt) begin
          rem = rem - (root + bt);
          root = (root >> 1) + bt;
        end else begin
          root = root >> 1;
        end
        bt = bt >> 2;
      end
      for (int i = 0; i < 3; i++) begin
        mag = longint'(v[i] < 0 ? -v[i] : v[i]) << 28;
        q = longint'((mag + root / 2) / root);
        n[i] = sat_unit(v[i] < 0 ? -q : q);
      end
    end
    // fold the angle into the convergence range
    zq = longint'(rq.angle) * 131072;
    if (zq > HALF_PI_Z) begin
      zq = zq - PI_Z;
      flip = 1'b1;
    end else if (zq < -HALF_PI_Z) begin
      zq = zq + PI_Z;
      flip = 1'b1;
    end
    // rotation-mode cordic
    cx = GAIN_Q30;
    cy = 0;
    for (int i = 0; i < aarm_pkg::CORDIC_ITER; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (zq >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        zq = zq - longint'(aarm_pkg::atan_q30(i));
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        zq = zq + longint'(aarm_pkg::atan_q30(i));
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    c = sat_unit((cx + 32768) >>> 16);
    s = sat_unit((cy + 32768) >>> 16);
    t = ONE_UNIT - c;
    res.m[0] = round_entry((c <<< 28) + n[0] * n[0] * t);
    res.m[1] = round_entry(n[0] * n[1] * t - n[2] * s * ONE_UNIT);
    res.m[2] = round_entry(n[0] * n[2] * t + n[1] * s * ONE_UNIT);
    res.m[3] = round_entry(n[1] * n[0] * t + n[2] * s * ONE_UNIT);
    res.m[4] = round_entry((c <<< 28) + n[1] * n[1] * t);
    res.m[5] = round_entry(n[1] * n[2] * t - n[0] * s * ONE_UNIT);
    res.m[6] = round_entry(n[2] * n[0] * t - n[1] * s * ONE_UNIT);
    res.m[7] = round_entry(n[2] * n[1] * t + n[0] * s * ONE_UNIT);
    res.m[8] = round_entry((c <<< 28) + n[2] * n[2] * t);
    return res;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic queue_request(input int x, input int y, input int z, input int a);
    rot_request_t rq;
    rq.ax = aarm_pkg::axis_t'(x);
    rq.ay = aarm_pkg::axis_t'(y);
    rq.az = aarm_pkg::axis_t'(z);
    rq.angle = aarm_pkg::axis_t'(a);
    pending_requests.push_back(rq);
  endtask

  function automatic int rand_s16();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // request driver: idles at random outside a back-to-back stretch
  always @(posedge clk) begin
    rot_request_t rq;
    bit take;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_matrices.push_back(predict_rotation('{in_axis_x, in_axis_y, in_axis_z,
                                                       in_turn_angle}));
        accepted_count++;
      end
      if (start && busy) begin
        take = 1'b0;
      end else begin
        take = pending_requests.size() != 0 &&
               ((accepted_count > 400 && accepted_count < 700) ||
                $urandom_range(99) >= 19);
        if (take) begin
          rq = pending_requests.pop_front();
          in_axis_x     <= rq.ax;
          in_axis_y     <= rq.ay;
          in_axis_z     <= rq.az;
          in_turn_angle <= rq.angle;
        end
        start <= take;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rot_matrix_t want;
    aarm_pkg::q14_t got[9];
    if (rst_n && out_valid) begin
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21,
              out_m22};
      if (expected_matrices.size() == 0) begin
        error_count++;
        $display("[%0t] matrix strobe with no request outstanding", $time);
      end else begin
        want = expected_matrices.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.m[i])
            report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), got[i], want.m[i]);
        end
        if (out_zero_axis !== want.zero_axis)
          report_mismatch("zero_axis", out_zero_axis, want.zero_axis);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int kind;
    int x, y, z, a;
    rst_n = 1'b0;
    start = 1'b0;
    in_axis_x = '0;
    in_axis_y = '0;
    in_axis_z = '0;
    in_turn_angle = '0;
    error_count = 0;
    accepted_count = 0;
    cycle_count = 0;

    // directed: zero axis, field extremes, the half-pi fold boundaries
    queue_request(0, 0, 0, 0);
    queue_request(0, 0, 0, 32767);
    queue_request(0, 0, 0, -32768);
    queue_request(1, 0, 0, 12867);
    queue_request(0, 1, 0, 12868);
    queue_request(0, 0, 1, -12867);
    queue_request(0, 0, -1, -12868);
    queue_request(-32768, -32768, -32768, 32767);
    queue_request(32767, 32767, 32767, -32768);
    queue_request(-32768, 0, 0, 25736);
    queue_request(0, -32768, 0, -25736);
    queue_request(0, 0, 32767, 6434);
    queue_request(32767, -32768, 1, 1);
    queue_request(-1, -1, -1, -1);
    queue_request(1, 1, 1, 0);
    queue_request(3, 4, 0, 8579);
    queue_request(-32768, 32767, 0, 12868);
    queue_request(0, 0, 0, -12868);

    // random: mostly full range, plus short axes, single-axis and zero axes
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      kind = $urandom_range(99);
      x = rand_s16();
      y = rand_s16();
      z = rand_s16();
      a = rand_s16();
      if (kind < 15) begin
        x = int'($urandom_range(16)) - 8;
        y = int'($urandom_range(16)) - 8;
        z = int'($urandom_range(16)) - 8;
      end else if (kind < 25) begin
        case ($urandom_range(2))
          0: begin y = 0; z = 0; end
          1: begin x = 0; z = 0; end
          default: begin x = 0; y = 0; end
        endcase
      end else if (kind < 30) begin
        x = 0; y = 0; z = 0;
      end
      if ($urandom_range(9) == 0)
        a = ($urandom_range(1) ? 12868 : -12868) + int'($urandom_range(4)) - 2;
      queue_request(x, y, z, a);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then allow the pipeline depth
    while (pending_requests.size() != 0 || start || expected_matrices.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_matrices.size() != 0) begin
      error_count++;
      $display("%0d matrices never arrived", expected_matrices.size());
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
